@@ hw/rtl/mlrq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_pkg: shared types and constants
// Opcodes, status codes, word types and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int LEVELS_DEF = 8;
    localparam int IDS_DEF    = 32;
    localparam int NODES_DEF  = 32;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_ROT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_PRIO  = 2'd2;
    localparam logic [1:0] ST_NO_MEM    = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] proc_id;
        logic [3:0] level;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] out_id;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

    typedef struct packed {
        logic done;
    } sts_t;

endpackage

@@ hw/rtl/mlrq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_datapath: queue storage and update logic
// The load step latches the command and reads node memories; the execute step updates.
// ----------------------------------------------------------------------------
module mlrq_datapath #(
    parameter int LEVELS = mlrq_pkg::LEVELS_DEF,
    parameter int IDS    = mlrq_pkg::IDS_DEF,
    parameter int NODES  = mlrq_pkg::NODES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mlrq_pkg::ctl_t ctl,
    input  mlrq_pkg::cmd_t cmd,
    output mlrq_pkg::sts_t sts,
    output mlrq_pkg::rsp_t rsp
);
    import mlrq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int IW = (IDS > 1) ? $clog2(IDS) : 1;

    logic [NW-1:0] head_reg [LEVELS];
    logic [NW-1:0] tail_reg [LEVELS];
    logic [LEVELS-1:0] busy_reg;
    logic [IW-1:0] owner_mem [NODES];
    logic [NW-1:0] link_mem [NODES];
    logic [NW-1:0] free_mem [NODES];
    logic [CW-1:0] free_cnt_reg;
    logic [CW-1:0] init_cnt_reg;

    cmd_t          cmd_reg;
    logic [NW-1:0] free_rd_reg;
    logic [NW-1:0] hlink_rd_reg;
    logic [IW-1:0] howner_rd_reg;
    logic          done_reg;
    rsp_t          rsp_reg;

    logic          lvl_ok;
    logic [LW-1:0] li;
    logic [LW-1:0] cli;
    logic          pid_ok;
    logic [NW-1:0] h;
    logic [NW-1:0] t;
    logic          busy;
    logic          enq_go;
    logic          deq_go;
    logic          rot_go;
    logic [1:0]    st;
    logic          init_done;

    assign init_done = (init_cnt_reg == CW'(NODES));
    assign li  = cmd.level[LW-1:0];
    assign cli = cmd_reg.level[LW-1:0];
    assign lvl_ok = ({28'd0, cmd_reg.level} < 32'(LEVELS));
    assign pid_ok = ({26'd0, cmd_reg.proc_id} < 32'(IDS));
    assign h = head_reg[cli];
    assign t = tail_reg[cli];
    assign busy = busy_reg[cli];

    always_comb
    begin
        enq_go = 1'b0;
        deq_go = 1'b0;
        rot_go = 1'b0;
        st = ST_NOT_FOUND;
        case (cmd_reg.opcode)
            OP_ENQ:
            begin
                if (!pid_ok)
                    st = ST_NOT_FOUND;
                else if (!lvl_ok)
                    st = ST_BAD_PRIO;
                else if (free_cnt_reg == '0)
                    st = ST_NO_MEM;
                else
                begin
                    st = ST_OK;
                    enq_go = 1'b1;
                end
            end
            OP_DEQ, OP_ROT:
            begin
                if (!lvl_ok)
                    st = ST_BAD_PRIO;
                else if (!busy)
                    st = ST_NOT_FOUND;
                else
                begin
                    st = ST_OK;
                    deq_go = (cmd_reg.opcode == OP_DEQ);
                    rot_go = (cmd_reg.opcode == OP_ROT) && (h != t);
                end
            end
            default: st = ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg       <= cmd;
            free_rd_reg   <= free_mem[free_cnt_reg[NW-1:0] - NW'(1)];
            hlink_rd_reg  <= link_mem[head_reg[li]];
            howner_rd_reg <= owner_mem[head_reg[li]];
        end
        if (!init_done)
            free_mem[init_cnt_reg[NW-1:0]] <= init_cnt_reg[NW-1:0];
        else if (ctl.exec && deq_go)
            free_mem[free_cnt_reg[NW-1:0]] <= h;
        if (ctl.exec && enq_go)
        begin
            owner_mem[free_rd_reg] <= cmd_reg.proc_id[IW-1:0];
            link_mem[free_rd_reg]  <= '0;
        end
        if (ctl.exec && enq_go && busy)
            link_mem[t] <= free_rd_reg;
        if (ctl.exec && rot_go)
        begin
            link_mem[t] <= h;
            link_mem[h] <= '0;
        end
        if (ctl.exec && enq_go)
        begin
            tail_reg[cli] <= free_rd_reg;
            if (!busy)
                head_reg[cli] <= free_rd_reg;
        end
        if (ctl.exec && deq_go && (h != t))
            head_reg[cli] <= hlink_rd_reg;
        if (ctl.exec && rot_go)
        begin
            head_reg[cli] <= hlink_rd_reg;
            tail_reg[cli] <= h;
        end
        if (ctl.exec)
        begin
            rsp_reg.status <= st;
            rsp_reg.out_id <= (deq_go) ? 5'(howner_rd_reg) : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= '0;
            free_cnt_reg <= CW'(NODES);
            init_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.exec;
            if (!init_done)
                init_cnt_reg <= init_cnt_reg + CW'(1);
            if (ctl.exec && enq_go)
            begin
                busy_reg[cli] <= 1'b1;
                free_cnt_reg  <= free_cnt_reg - CW'(1);
            end
            if (ctl.exec && deq_go)
            begin
                if (h == t)
                    busy_reg[cli] <= 1'b0;
                free_cnt_reg <= free_cnt_reg + CW'(1);
            end
        end
    end

    assign sts.done = init_done;
    assign rsp = done_reg ? rsp_reg : '0;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= CW'(NODES))
        else $error("free count overflow");
    a_enq_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && enq_go) |=> (free_cnt_reg == $past(free_cnt_reg) - CW'(1)))
        else $error("enqueue did not take a node");
    a_deq_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && deq_go) |=> (free_cnt_reg == $past(free_cnt_reg) + CW'(1)))
        else $error("dequeue did not free a node");
`endif

endmodule

@@ hw/rtl/mlrq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_ctrl: command sequencer
// Waits for free-list init, then runs each command as load then execute.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mlrq_pkg::sts_t sts,
    output logic           busy,
    output mlrq_pkg::ctl_t ctl,
    output logic           strobe
);
    import mlrq_pkg::*;

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       strobe_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl.load = 1'b0;
        ctl.exec = 1'b0;
        case (state_reg)
            S_INIT: if (sts.done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= ctl.exec;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;

`ifndef ASSERT_OFF
    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec)
        else $error("load not followed by execute");
    a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> strobe)
        else $error("execute without result");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.exec))
        else $error("load and execute together");
`endif

endmodule

@@ hw/rtl/multilevel_ready_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_core: per-priority FIFO of process ids
// Linked-list queues over a shared node pool with a free-node stack.
// ----------------------------------------------------------------------------
// After reset busy stays high while the free-node stack is filled. Each
// command then runs as a load step that latches it and reads the node
// memories, then an execute step that updates; the result word appears
// in the cycle after the execute step with strobe high for one cycle, and
// busy is low again in that cycle, so a new command can start as it is shown.
module multilevel_ready_queue_core #(
    parameter int LEVELS = mlrq_pkg::LEVELS_DEF,
    parameter int IDS    = mlrq_pkg::IDS_DEF,
    parameter int NODES  = mlrq_pkg::NODES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mlrq_pkg::cmd_t cmd,
    output logic           strobe,
    output mlrq_pkg::rsp_t rsp
);
    import mlrq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    mlrq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (sts),
        .busy   (busy),
        .ctl    (ctl),
        .strobe (strobe)
    );

    mlrq_datapath #(
        .LEVELS (LEVELS),
        .IDS    (IDS),
        .NODES  (NODES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

@@ tb/sv/multilevel_ready_queue_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_core_tb: self-checking bench for the ready queue
// Drives enqueue, dequeue and rotate commands under several idle patterns,
// predicts every response word with a behavioral queue model and compares.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_core_tb;
    import mlrq_pkg::*;

    localparam int LEVELS = 8;
    localparam int IDS    = 32;
    localparam int NODES  = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic strobe;
    rsp_t rsp;

    multilevel_ready_queue_core #(
        .LEVELS(LEVELS),
        .IDS(IDS),
        .NODES(NODES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .strobe(strobe),
        .rsp(rsp)
    );

    // predicted queue contents: pids per level, plus pool occupancy
    int unsigned level_pids[LEVELS][$];
    int          nodes_used;
    rsp_t        pending_rsp[$];
    int          error_count = 0;
    int          idle_pct;
    int          stall_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what);
        begin
            error_count++;
            $display("ERROR %0t: %s", $realtime, what);
        end
    endtask

    function automatic rsp_t queue_apply(input cmd_t c);
        rsp_t        r;
        int unsigned p;
        begin
            r.status = ST_NOT_FOUND;
            r.out_id = '0;
            if (c.opcode == OP_ENQ)
            begin
                if (c.proc_id >= IDS) r.status = ST_NOT_FOUND;
                else if (c.level >= LEVELS) r.status = ST_BAD_PRIO;
                else if (nodes_used >= NODES) r.status = ST_NO_MEM;
                else
                begin
                    level_pids[c.level].push_back(c.proc_id);
                    nodes_used++;
                    r.status = ST_OK;
                end
            end
            else if (c.opcode == OP_DEQ || c.opcode == OP_ROT)
            begin
                if (c.level >= LEVELS) r.status = ST_BAD_PRIO;
                else if (level_pids[c.level].size() == 0) r.status = ST_NOT_FOUND;
                else
                begin
                    p = level_pids[c.level].pop_front();
                    r.status = ST_OK;
                    if (c.opcode == OP_DEQ)
                    begin
                        r.out_id = p[4:0];
                        nodes_used--;
                    end
                    else
                    begin
                        level_pids[c.level].push_back(p);
                    end
                end
            end
            return r;
        end
    endfunction

    task automatic send_word(input cmd_t c);
        begin
            while ($urandom_range(99, 0) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            cmd   <= c;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_rsp.push_back(queue_apply(c));
        end
    endtask

    task automatic send_op(input logic [1:0] op, input int pid, input int lvl);
        cmd_t c;
        begin
            c.opcode  = op;
            c.proc_id = pid[5:0];
            c.level   = lvl[3:0];
            send_word(c);
        end
    endtask

    task automatic wait_drained();
        begin
            start <= 1'b0;
            while (pending_rsp.size() != 0)
                @(posedge clk);
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && strobe)
        begin
            if (pending_rsp.size() == 0) report("response with none pending");
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.status !== exp_rsp.status)
                    report($sformatf("status %0d, predicted %0d", rsp.status,
                                     exp_rsp.status));
                if (rsp.out_id !== exp_rsp.out_id)
                    report($sformatf("out_id %0d, predicted %0d", rsp.out_id,
                                     exp_rsp.out_id));
            end
        end
    end

    // watchdog: cycles with no accepted word
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multilevel_ready_queue_core: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        begin
            send_op(OP_DEQ, 0, 0);
            send_op(OP_ROT, 0, 7);
            send_op(OP_ENQ, 63, 0);
            send_op(OP_ENQ, 32, 0);
            send_op(OP_ENQ, 5, 15);
            send_op(OP_DEQ, 0, 8);
            send_op(OP_ROT, 0, 15);
            send_op(OP_ENQ, 31, 7);
            send_op(OP_ROT, 0, 7);
            send_op(OP_ENQ, 0, 7);
            send_op(OP_ENQ, 21, 7);
            send_op(OP_ROT, 0, 7);
            send_op(OP_DEQ, 0, 7);
            send_op(OP_DEQ, 0, 7);
            send_op(OP_DEQ, 0, 7);
            send_op(OP_DEQ, 0, 7);
            send_op(2'd3, 63, 15);
            send_op(2'd3, 0, 0);
        end
    endtask

    task automatic test_pool_exhaust();
        begin
            for (int i = 0; i < NODES + 2; i++)
                send_op(OP_ENQ, $urandom_range(IDS - 1, 0), $urandom_range(LEVELS - 1, 0));
            send_op(OP_ROT, 0, 3);
            for (int l = 0; l < LEVELS; l++)
                while (level_pids[l].size() != 0) send_op(OP_DEQ, 0, l);
            wait_drained();
        end
    endtask

    task automatic test_random(input int count, input int pct);
        int k;
        int lvl;
        begin
            idle_pct = pct;
            for (int i = 0; i < count; i++)
            begin
                k = $urandom_range(99, 0);
                lvl = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0)
                                                  : $urandom_range(LEVELS - 1, 0);
                if (k < 45)
                    send_op(OP_ENQ, ($urandom_range(9, 0) == 0) ? $urandom_range(63, 0)
                                    : $urandom_range(IDS - 1, 0), lvl);
                else if (k < 80) send_op(OP_DEQ, $urandom_range(63, 0), lvl);
                else if (k < 97) send_op(OP_ROT, $urandom_range(63, 0), lvl);
                else send_op(2'd3, $urandom_range(63, 0), $urandom_range(15, 0));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_pct = 0;
        nodes_used = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_exhaust();
        test_random(400, 0);
        test_random(400, 46);
        wait_drained();
        repeat ($urandom_range(5, 1)) @(posedge clk);
        test_random(400, 9);
        test_random(400, 0);
        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0) $display("multilevel_ready_queue_core: match");
        else $display("multilevel_ready_queue_core: mismatch");
        $finish;
    end
endmodule

@@ multilevel_ready_queue_core.f @@
hw/rtl/mlrq_pkg.sv
hw/rtl/mlrq_datapath.sv
hw/rtl/mlrq_ctrl.sv
hw/rtl/multilevel_ready_queue_core.sv
tb/sv/multilevel_ready_queue_core_tb.sv
